// ----- hdl/assert_macros.svh -----
// assertion macros shared by the hsv to rgb rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- hdl/hsv2rgb_pkg.sv -----
// shared types and constants for the hsv to rgb converter
// no dependencies
`default_nettype none
package hsv2rgb_pkg;

  localparam int unsigned CHAN_W = 16;
  localparam int unsigned FRAC_W = 16;
  localparam logic [CHAN_W-1:0] ONE_Q15 = 16'd32768;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

endpackage
`default_nettype wire

// ----- hdl/hsv2rgb_ifs.sv -----
// valid/ready stream interfaces carrying one hsv pixel and one rgb pixel
// depends on hsv2rgb_pkg
`default_nettype none
interface hsv2rgb_hsv_if import hsv2rgb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] hue;
  logic [CHAN_W-1:0] saturation;
  logic [CHAN_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink (input valid, input hue, input saturation, input brightness, output ready);
endinterface

interface hsv2rgb_rgb_if import hsv2rgb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ----- hdl/hsv_to_rgb_converter.sv -----
// hsv to rgb pixel converter, four register stages
// depends on hsv2rgb_pkg, hsv2rgb_ifs and assert_macros.svh
// output valid: an input transfer sets v1 and moves on through v2 and v3 to v4, one register per stage
// throughput: one pixel per cycle while rgb.ready is high; each stage moves when the stage after it is free
// reset: synchronous rst clears all stage valid bits; payload registers are not reset
`default_nettype none
`include "assert_macros.svh"
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  hsv2rgb_hsv_if.sink       hsv,
  hsv2rgb_rgb_if.source     rgb
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // stage 1: clamp, sector and fraction
  logic [CHAN_W-1:0]   s1_sat, s1_val;
  logic [FRAC_W-1:0]   s1_frac;
  sector_t             s1_sec;
  logic [FRAC_W+2:0]   h6;
  logic [CHAN_W-1:0]   sat_clamp, val_clamp;

  // stage 2: s*f, s*(1-f), p
  logic [CHAN_W-1:0]   s2_sf, s2_snf, s2_p, s2_val;
  sector_t             s2_sec;
  logic [2*CHAN_W-1:0] sf_prod, p_prod;
  logic [2*CHAN_W-1:0] snf_prod;
  logic [FRAC_W:0]     frac_rest;

  // stage 3: q, t
  logic [CHAN_W-1:0]   s3_q, s3_t, s3_p, s3_val;
  sector_t             s3_sec;
  logic [2*CHAN_W-1:0] q_prod, t_prod;

  // stage 4: routed output
  logic [CHAN_W-1:0]   red, green, blue;
  logic [CHAN_W-1:0]   red_next, green_next, blue_next;

  assign en4 = !v4 || rgb.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign hsv.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= hsv.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_comb begin
    sat_clamp = (hsv.saturation > ONE_Q15) ? ONE_Q15 : hsv.saturation;
    val_clamp = (hsv.brightness > ONE_Q15) ? ONE_Q15 : hsv.brightness;
    h6 = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sat  <= sat_clamp;
      s1_val  <= val_clamp;
      s1_frac <= h6[FRAC_W-1:0];
      s1_sec  <= sector_t'(h6[FRAC_W+2:FRAC_W]);
    end
  end

  always_comb begin
    frac_rest = {1'b1, {FRAC_W{1'b0}}} - {1'b0, s1_frac};
    sf_prod   = (2*CHAN_W)'(s1_sat) * (2*CHAN_W)'(s1_frac);
    snf_prod  = (2*CHAN_W)'(s1_sat) * (2*CHAN_W)'(frac_rest);
    p_prod    = (2*CHAN_W)'(s1_val) * (2*CHAN_W)'(ONE_Q15 - s1_sat);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sf  <= sf_prod[2*CHAN_W-1:FRAC_W];
      s2_snf <= snf_prod[2*CHAN_W-1:FRAC_W];
      s2_p   <= p_prod[2*CHAN_W-2:CHAN_W-1];
      s2_val <= s1_val;
      s2_sec <= s1_sec;
    end
  end

  always_comb begin
    q_prod = (2*CHAN_W)'(s2_val) * (2*CHAN_W)'(ONE_Q15 - s2_sf);
    t_prod = (2*CHAN_W)'(s2_val) * (2*CHAN_W)'(ONE_Q15 - s2_snf);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_q   <= q_prod[2*CHAN_W-2:CHAN_W-1];
      s3_t   <= t_prod[2*CHAN_W-2:CHAN_W-1];
      s3_p   <= s2_p;
      s3_val <= s2_val;
      s3_sec <= s2_sec;
    end
  end

  // zero saturation falls out as p = q = t = v
  always_comb begin
    unique case (s3_sec)
      SEC_RED_YELLOW: begin
        red_next = s3_val; green_next = s3_t; blue_next = s3_p;
      end
      SEC_YELLOW_GREEN: begin
        red_next = s3_q; green_next = s3_val; blue_next = s3_p;
      end
      SEC_GREEN_CYAN: begin
        red_next = s3_p; green_next = s3_val; blue_next = s3_t;
      end
      SEC_CYAN_BLUE: begin
        red_next = s3_p; green_next = s3_q; blue_next = s3_val;
      end
      SEC_BLUE_MAGENTA: begin
        red_next = s3_t; green_next = s3_p; blue_next = s3_val;
      end
      default: begin
        red_next = s3_val; green_next = s3_p; blue_next = s3_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign rgb.valid = v4;
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

  `ASSERT_AT(a_in_xfer_fills_s1, clk, rst, (hsv.valid && hsv.ready) |=> v1, "input transfer lost")
  `ASSERT_AT(a_s3_held_on_stall, clk, rst, (v3 && !en3) |=> v3, "stage 3 item dropped on stall")
  `ASSERT_NEVER(a_s1_clamped, clk, rst, v1 && (s1_sat > ONE_Q15 || s1_val > ONE_Q15), "clamp failed")
  `ASSERT_NEVER(a_s1_sector_range, clk, rst, v1 && s1_sec > SEC_MAGENTA_RED, "sector out of range")
  `ASSERT_NEVER(a_out_range, clk, rst, v4 && (red > ONE_Q15 || green > ONE_Q15 || blue > ONE_Q15),
                "output above one")

endmodule
`default_nettype wire
